[hdl/oopg_pkg.sv]
package oopg_pkg;

  localparam logic [2:0] CMD_AXES = 3'd0;
  localparam logic [2:0] CMD_EDGE = 3'd1;
  localparam logic [2:0] CMD_CUBE = 3'd2;
  localparam logic [2:0] CMD_AAB  = 3'd3;
  localparam logic [2:0] CMD_AB0  = 3'd4;
  localparam logic [2:0] CMD_ABC  = 3'd5;

  localparam logic [31:0] PI_Q30 = 32'hC90F_DAA2;

  typedef logic [1:0] slot_t;
  typedef slot_t [2:0] trip_t;

  localparam slot_t SLOT_Z = 2'd0;
  localparam slot_t SLOT_A = 2'd1;
  localparam slot_t SLOT_B = 2'd2;
  localparam slot_t SLOT_C = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [30:0] a;
    logic [30:0] b;
    logic [31:0] w;
    logic        neg;
  } item_t;

  typedef struct packed {
    trip_t      slots;
    logic [2:0] neg;
  } point_t;

  function automatic trip_t trip(input slot_t sx, input slot_t sy, input slot_t sz);
    trip_t t;
    t[0] = sx;
    t[1] = sy;
    t[2] = sz;
    return t;
  endfunction

  function automatic trip_t perm1(input logic [3:0] p);
    trip_t t;
    case (p)
      4'd0:    t = trip(SLOT_Z, SLOT_A, SLOT_B);
      4'd1:    t = trip(SLOT_A, SLOT_Z, SLOT_B);
      4'd2:    t = trip(SLOT_A, SLOT_B, SLOT_Z);
      default: t = trip(SLOT_Z, SLOT_Z, SLOT_Z);
    endcase
    return t;
  endfunction

  function automatic trip_t perm3(input logic [2:0] p);
    trip_t t;
    case (p)
      3'd0:    t = trip(SLOT_A, SLOT_A, SLOT_B);
      3'd1:    t = trip(SLOT_A, SLOT_B, SLOT_A);
      3'd2:    t = trip(SLOT_B, SLOT_A, SLOT_A);
      default: t = trip(SLOT_Z, SLOT_Z, SLOT_Z);
    endcase
    return t;
  endfunction

  function automatic trip_t perm4(input logic [3:0] p);
    trip_t t;
    case (p)
      4'd0:    t = trip(SLOT_A, SLOT_B, SLOT_Z);
      4'd1:    t = trip(SLOT_B, SLOT_A, SLOT_Z);
      4'd2:    t = trip(SLOT_A, SLOT_Z, SLOT_B);
      4'd3:    t = trip(SLOT_B, SLOT_Z, SLOT_A);
      4'd4:    t = trip(SLOT_Z, SLOT_A, SLOT_B);
      4'd5:    t = trip(SLOT_Z, SLOT_B, SLOT_A);
      default: t = trip(SLOT_Z, SLOT_Z, SLOT_Z);
    endcase
    return t;
  endfunction

  function automatic trip_t perm5(input logic [2:0] p);
    trip_t t;
    case (p)
      3'd0:    t = trip(SLOT_A, SLOT_B, SLOT_C);
      3'd1:    t = trip(SLOT_A, SLOT_C, SLOT_B);
      3'd2:    t = trip(SLOT_B, SLOT_A, SLOT_C);
      3'd3:    t = trip(SLOT_B, SLOT_C, SLOT_A);
      3'd4:    t = trip(SLOT_C, SLOT_A, SLOT_B);
      3'd5:    t = trip(SLOT_C, SLOT_B, SLOT_A);
      default: t = trip(SLOT_Z, SLOT_Z, SLOT_Z);
    endcase
    return t;
  endfunction

  function automatic logic [2:0] sign_mask(input logic [2:0] i);
    logic [2:0] m;
    case (i)
      3'd0:    m = 3'd0;
      3'd1:    m = 3'd1;
      3'd2:    m = 3'd2;
      3'd3:    m = 3'd4;
      3'd4:    m = 3'd3;
      3'd5:    m = 3'd5;
      3'd6:    m = 3'd6;
      default: m = 3'd7;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] cube_mask(input logic [2:0] i);
    logic [2:0] m;
    case (i)
      3'd0:    m = 3'd7;
      3'd1:    m = 3'd3;
      3'd2:    m = 3'd5;
      3'd3:    m = 3'd1;
      3'd4:    m = 3'd6;
      3'd5:    m = 3'd2;
      3'd6:    m = 3'd4;
      default: m = 3'd0;
    endcase
    return m;
  endfunction

  // signs over the two nonzero axes, first nonzero axis takes bit 0
  function automatic logic [2:0] pair_mask(input trip_t t, input logic [1:0] idx);
    logic [2:0] m;
    logic       sel;
    m   = 3'd0;
    sel = 1'b0;
    for (int ax = 0; ax < 3; ax++) begin
      if (t[ax] != SLOT_Z) begin
        m[ax] = idx[sel];
        sel   = 1'b1;
      end
    end
    return m;
  endfunction

  function automatic point_t point_map(input logic [2:0] cmd, input logic [5:0] k);
    point_t p;
    p.slots = trip(SLOT_Z, SLOT_Z, SLOT_Z);
    p.neg   = 3'd0;
    case (cmd)
      CMD_AXES: begin
        case (k[2:1])
          2'd0:    begin p.slots[0] = SLOT_A; p.neg[0] = k[0]; end
          2'd1:    begin p.slots[1] = SLOT_A; p.neg[1] = k[0]; end
          default: begin p.slots[2] = SLOT_A; p.neg[2] = k[0]; end
        endcase
      end
      CMD_EDGE: begin
        p.slots = perm1(k[5:2]);
        p.neg   = pair_mask(p.slots, k[1:0]);
      end
      CMD_CUBE: begin
        p.slots = trip(SLOT_A, SLOT_A, SLOT_A);
        p.neg   = cube_mask(k[2:0]);
      end
      CMD_AAB: begin
        p.slots = perm3(k[5:3]);
        p.neg   = sign_mask(k[2:0]);
      end
      CMD_AB0: begin
        p.slots = perm4(k[5:2]);
        p.neg   = pair_mask(p.slots, k[1:0]);
      end
      CMD_ABC: begin
        p.slots = perm5(k[5:3]);
        p.neg   = sign_mask(k[2:0]);
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic logic [5:0] orbit_len(input logic [2:0] cmd);
    logic [5:0] n;
    case (cmd)
      CMD_AXES: n = 6'd6;
      CMD_EDGE: n = 6'd12;
      CMD_CUBE: n = 6'd8;
      CMD_AAB:  n = 6'd24;
      CMD_AB0:  n = 6'd24;
      CMD_ABC:  n = 6'd48;
      default:  n = 6'd0;
    endcase
    return n;
  endfunction

endpackage

[hdl/oopg_in_if.sv]
interface oopg_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [30:0] first_gen;
  logic [30:0] second_gen;
  logic [31:0] weight_in;

  modport source (output valid, cmd, first_gen, second_gen, weight_in, input ready);
  modport sink   (input valid, cmd, first_gen, second_gen, weight_in, output ready);
endinterface

[hdl/oopg_out_if.sv]
interface oopg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_coord;
  logic [31:0] y_coord;
  logic [31:0] z_coord;
  logic [31:0] weight_out;
  logic        domain_flag;
  logic        last;

  modport source (output valid, x_coord, y_coord, z_coord, weight_out, domain_flag, last,
                  input ready);
  modport sink   (input valid, x_coord, y_coord, z_coord, weight_out, domain_flag, last,
                  output ready);
endinterface

[hdl/octahedral_orbit_point_generator.sv]
// Octahedral orbit point generator. Each input transaction names an orbit type
// (6, 12, 8, 24, 24 or 48 points) with generators a, b and a weight; the block
// emits every point of that orbit, one result transaction per cycle while the
// output is ready, with the weight times pi/2 and a flag when the root's
// radicand was negative. The front is a pipeline of COORD_FRAC_BITS + 5 stages
// (squares, radicand, one square-root bit per stage, rounding) that takes a new
// transaction every cycle unless stalled; the point sequencer at its end holds
// one orbit and sends its points out at one per cycle while the output is
// ready, taking the next transaction only as the last point of the current
// orbit leaves; types 6 and 7 give no results. Input ready drops only while a
// finished item waits at the end of the pipeline for the sequencer to free up.
module octahedral_orbit_point_generator #(
  parameter int COORD_FRAC_BITS = 30
) (
  input logic        clk,
  input logic        rst_n,
  oopg_in_if.sink    in_ch,
  oopg_out_if.source out_ch
);
  import oopg_pkg::*;

  logic                          adv;
  logic                          rad_v;
  item_t                         rad_item;
  logic [2*COORD_FRAC_BITS:0]    rad_val;
  logic                          root_v;
  item_t                         root_item;
  logic [COORD_FRAC_BITS:0]      root_val;
  logic [31:0]                   root_lo;

  oopg_front #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_ch    (in_ch),
    .rad_v    (rad_v),
    .rad_item (rad_item),
    .rad_val  (rad_val)
  );

  oopg_sqrt #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .rad_v     (rad_v),
    .rad_item  (rad_item),
    .rad_val   (rad_val),
    .root_v    (root_v),
    .root_item (root_item),
    .root_val  (root_val)
  );

  assign root_lo = 32'(root_val);

  oopg_expand #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_expand (
    .clk       (clk),
    .rst_n     (rst_n),
    .tail_v    (root_v),
    .tail_item (root_item),
    .tail_root (root_lo),
    .adv       (adv),
    .out_ch    (out_ch)
  );

endmodule

[hdl/oopg_front.sv]
module oopg_front #(
  parameter int COORD_FRAC_BITS = 30
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  oopg_in_if.sink                       in_ch,
  output logic                          rad_v,
  output oopg_pkg::item_t               rad_item,
  output logic [2*COORD_FRAC_BITS:0]    rad_val
);
  import oopg_pkg::*;

  localparam int RADW = 2 * COORD_FRAC_BITS + 1;
  localparam int SW   = 63;
  localparam int DW   = ((RADW > SW) ? RADW : SW) + 1;

  logic        a_v_r;
  item_t       a_item_r;
  logic [61:0] aa_r;
  logic [61:0] bb_r;
  logic [63:0] wp_r;

  logic        b_v_r;
  item_t       b_item_r;
  item_t       b_item_nxt;
  logic [62:0] s_r;
  logic [62:0] s_nxt;
  logic [64:0] wsum;
  logic [33:0] wsh;
  logic [31:0] w_nxt;

  logic        c_v_r;
  item_t       c_item_r;
  item_t       c_item_nxt;
  logic [RADW-1:0] c_rad_r;
  logic [DW-1:0]   diff;

  assign in_ch.ready = adv;

  // stage a: squares and weight product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_ch.valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_item_r.cmd <= in_ch.cmd;
      a_item_r.a   <= in_ch.first_gen;
      a_item_r.b   <= in_ch.second_gen;
      a_item_r.w   <= in_ch.weight_in;
      a_item_r.neg <= 1'b0;
      aa_r         <= 62'(in_ch.first_gen) * 62'(in_ch.first_gen);
      bb_r         <= 62'(in_ch.second_gen) * 62'(in_ch.second_gen);
      wp_r         <= 64'(in_ch.weight_in) * 64'(PI_Q30);
    end
  end

  // stage b: radicand sum, weight rounding
  always_comb begin
    case (a_item_r.cmd)
      CMD_EDGE: s_nxt = 63'(aa_r);
      CMD_AB0:  s_nxt = 63'(aa_r);
      CMD_AAB:  s_nxt = {aa_r, 1'b0};
      CMD_ABC:  s_nxt = 63'(aa_r) + 63'(bb_r);
      default:  s_nxt = '0;
    endcase
    wsum  = 65'(wp_r) + (65'(1) << 30);
    wsh   = wsum[64:31];
    w_nxt = (wsh[33:32] != 2'b00) ? 32'hFFFF_FFFF : wsh[31:0];
    b_item_nxt   = a_item_r;
    b_item_nxt.w = w_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_item_r <= b_item_nxt;
      s_r      <= s_nxt;
    end
  end

  // stage c: subtract from one squared, clamp below zero
  assign diff = (DW'(1) << (2 * COORD_FRAC_BITS)) - DW'(s_r);

  always_comb begin
    c_item_nxt     = b_item_r;
    c_item_nxt.neg = diff[DW-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_item_r <= c_item_nxt;
      c_rad_r  <= diff[DW-1] ? '0 : diff[RADW-1:0];
    end
  end

  assign rad_v    = c_v_r;
  assign rad_item = c_item_r;
  assign rad_val  = c_rad_r;

endmodule

[hdl/oopg_sqrt.sv]
module oopg_sqrt #(
  parameter int COORD_FRAC_BITS = 30
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          rad_v,
  input  oopg_pkg::item_t               rad_item,
  input  logic [2*COORD_FRAC_BITS:0]    rad_val,
  output logic                          root_v,
  output oopg_pkg::item_t               root_item,
  output logic [COORD_FRAC_BITS:0]      root_val
);
  import oopg_pkg::*;

  localparam int NST  = COORD_FRAC_BITS + 1;
  localparam int RTW  = COORD_FRAC_BITS + 1;
  localparam int REMW = 2 * COORD_FRAC_BITS + 2;

  logic            v_r    [NST];
  item_t           item_r [NST];
  logic [REMW-1:0] rem_r  [NST];
  logic [RTW-1:0]  root_r [NST];

  logic            out_v_r;
  item_t           out_item_r;
  logic [RTW-1:0]  out_root_r;

  // one result bit per stage, most significant first
  for (genvar g = 0; g < NST; g++) begin : g_stage
    localparam int BIT = COORD_FRAC_BITS - g;
    logic            v_in;
    item_t           item_in;
    logic [REMW-1:0] rem_in;
    logic [RTW-1:0]  root_in;
    logic [REMW-1:0] trial;

    if (g == 0) begin : g_first
      assign v_in    = rad_v;
      assign item_in = rad_item;
      assign rem_in  = REMW'(rad_val);
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_r[g-1];
      assign item_in = item_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
    end

    assign trial = (REMW'(root_in) << (BIT + 1)) + (REMW'(1) << (2 * BIT));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (adv) begin
        v_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        item_r[g] <= item_in;
        if (rem_in >= trial) begin
          rem_r[g]  <= rem_in - trial;
          root_r[g] <= root_in | (RTW'(1) << BIT);
        end else begin
          rem_r[g]  <= rem_in;
          root_r[g] <= root_in;
        end
      end
    end
  end

  // round to nearest: up when the remainder exceeds the root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= v_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= item_r[NST-1];
      out_root_r <= root_r[NST-1] + RTW'(rem_r[NST-1] > REMW'(root_r[NST-1]));
    end
  end

  assign root_v    = out_v_r;
  assign root_item = out_item_r;
  assign root_val  = out_root_r;

endmodule

[hdl/oopg_expand.sv]
module oopg_expand #(
  parameter int COORD_FRAC_BITS = 30
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            tail_v,
  input  oopg_pkg::item_t tail_item,
  input  logic [31:0]     tail_root,
  output logic            adv,
  oopg_out_if.source      out_ch
);
  import oopg_pkg::*;

  localparam logic [31:0] ONE_LO = 32'(64'd1 << COORD_FRAC_BITS);

  logic        exp_v_r;
  logic        exp_v_nxt;
  logic [5:0]  k_r;
  logic [5:0]  k_nxt;
  logic [2:0]  cmd_r;
  logic [31:0] va_r;
  logic [31:0] vb_r;
  logic [31:0] vc_r;
  logic [31:0] w_r;
  logic        flag_r;

  point_t      pt;
  logic        last_pt;
  logic        out_fire;
  logic        free;
  logic        take;

  function automatic logic [31:0] coord(input slot_t s, input logic n,
                                        input logic [31:0] va, input logic [31:0] vb,
                                        input logic [31:0] vc);
    logic [31:0] v;
    case (s)
      SLOT_A:  v = va;
      SLOT_B:  v = vb;
      SLOT_C:  v = vc;
      default: v = 32'd0;
    endcase
    return n ? (32'd0 - v) : v;
  endfunction

  assign pt       = point_map(cmd_r, k_r);
  assign last_pt  = (k_r == 6'(orbit_len(cmd_r) - 6'd1));
  assign out_fire = exp_v_r && out_ch.ready;
  assign free     = !exp_v_r || (out_fire && last_pt);
  assign take     = tail_v && free;
  assign adv      = !tail_v || free;

  always_comb begin
    exp_v_nxt = exp_v_r;
    k_nxt     = k_r;
    if (take) begin
      exp_v_nxt = (tail_item.cmd <= CMD_ABC);
      k_nxt     = 6'd0;
    end else if (out_fire) begin
      k_nxt = k_r + 6'd1;
      if (last_pt) begin
        exp_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_v_r <= 1'b0;
      k_r     <= 6'd0;
    end else begin
      exp_v_r <= exp_v_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r  <= tail_item.cmd;
      va_r   <= (tail_item.cmd == CMD_AXES) ? ONE_LO : {1'b0, tail_item.a};
      vb_r   <= (tail_item.cmd == CMD_ABC) ? {1'b0, tail_item.b} : tail_root;
      vc_r   <= tail_root;
      w_r    <= tail_item.w;
      flag_r <= tail_item.neg;
    end
  end

  assign out_ch.valid       = exp_v_r;
  assign out_ch.x_coord     = coord(pt.slots[0], pt.neg[0], va_r, vb_r, vc_r);
  assign out_ch.y_coord     = coord(pt.slots[1], pt.neg[1], va_r, vb_r, vc_r);
  assign out_ch.z_coord     = coord(pt.slots[2], pt.neg[2], va_r, vb_r, vc_r);
  assign out_ch.weight_out  = w_r;
  assign out_ch.domain_flag = flag_r;
  assign out_ch.last        = last_pt;

endmodule
